FILE: hdl/fpfa_pkg.sv
package fpfa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  // port field widths
  localparam int KIND_W    = 1;
  localparam int PIDX_W    = 4;
  localparam int AMT_W     = 16;
  localparam int STAT_W    = 2;
  localparam int MODE_W    = 2;
  localparam int BCNT_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // internal widths
  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BC_EXT_W  = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
  // wide enough to hold NUM_BLOCKS itself for the load range check
  localparam int PI_EXT_W  = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
  localparam int AM_EXT_W  = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC  = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_ZERO   = 2'd2,
    ST_LOADED = 2'd3
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE    = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;
    logic scan_done;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hdl/fpfa_ctrl.sv
module fpfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fpfa_pkg::dp_stat_t stat_i,
  output fpfa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.direct) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.step = 1'b1;
          if (stat_i.scan_done) begin
            state_d = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: hdl/fpfa_dp.sv
module fpfa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fpfa_pkg::ctrl_cmd_t               cmd_i,
  output fpfa_pkg::dp_stat_t                stat_o,
  input  logic [fpfa_pkg::KIND_W-1:0]       kind_i,
  input  logic [fpfa_pkg::PIDX_W-1:0]       part_index_i,
  input  logic [fpfa_pkg::AMT_W-1:0]        amount_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpfa_pkg::STAT_W-1:0]       status_o,
  output logic [fpfa_pkg::PIDX_W-1:0]       chosen_index_o,
  output logic [fpfa_pkg::AMT_W-1:0]        space_left_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fpfa_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int IDX_W    = fpfa_pkg::IDX_W;
  localparam int CNT_W    = fpfa_pkg::CNT_W;
  localparam int SIZE_W   = fpfa_pkg::SIZE_BITS;
  localparam int AM_EXT_W = fpfa_pkg::AM_EXT_W;
  localparam int PI_EXT_W = fpfa_pkg::PI_EXT_W;
  localparam int BC_EXT_W = fpfa_pkg::BC_EXT_W;

  // configuration
  fpfa_pkg::fit_mode_e              fit_mode_q;
  logic [fpfa_pkg::BCNT_W-1:0]      block_count_q;

  // partition table and next-fit pointer
  logic [SIZE_W-1:0]                free_q [fpfa_pkg::NUM_BLOCKS];
  logic [IDX_W-1:0]                 rover_q;

  // request
  fpfa_pkg::kind_e                  kind_q;
  logic [fpfa_pkg::PIDX_W-1:0]      part_index_q;
  logic [fpfa_pkg::AMT_W-1:0]       amount_q;
  logic [CNT_W-1:0]                 n_q;

  // scan
  logic [CNT_W-1:0]                 k_q;
  logic [IDX_W-1:0]                 j_q;
  logic                             found_q;
  logic [IDX_W-1:0]                 sel_q;
  logic [SIZE_W-1:0]                selval_q;

  // result word
  logic                             out_valid_q;
  fpfa_pkg::status_e                status_q, status_d;
  logic [fpfa_pkg::PIDX_W-1:0]      chosen_q, chosen_d;
  logic [fpfa_pkg::AMT_W-1:0]       left_q, left_d;

  logic [BC_EXT_W-1:0]              bc_ext;
  logic [CNT_W-1:0]                 n_new;
  logic [IDX_W-1:0]                 start_idx;
  logic [AM_EXT_W-1:0]              amt_ext;
  logic [AM_EXT_W-1:0]              sat_ext;
  logic [SIZE_W-1:0]                sat_val;
  logic [SIZE_W-1:0]                cur;
  logic                             fits;
  logic                             better;
  logic                             first_kind;
  logic                             last;
  logic [CNT_W-1:0]                 j_inc;
  logic [CNT_W-1:0]                 sel_inc;
  logic [SIZE_W-1:0]                remain;
  logic                             load_ok;

  assign bc_ext = BC_EXT_W'(block_count_q);
  assign n_new  = (bc_ext > BC_EXT_W'(fpfa_pkg::NUM_BLOCKS)) ?
                  CNT_W'(fpfa_pkg::NUM_BLOCKS) : CNT_W'(bc_ext);
  // stale pointer restarts at zero
  assign start_idx = (fit_mode_q == fpfa_pkg::FIT_NEXT && CNT_W'(rover_q) < n_new) ?
                     rover_q : '0;

  assign amt_ext = AM_EXT_W'(amount_q);
  assign sat_ext = (amt_ext > AM_EXT_W'({SIZE_W{1'b1}})) ?
                   AM_EXT_W'({SIZE_W{1'b1}}) : amt_ext;
  assign sat_val = SIZE_W'(sat_ext);
  assign load_ok = PI_EXT_W'(part_index_q) < PI_EXT_W'(fpfa_pkg::NUM_BLOCKS);

  assign cur        = free_q[j_q];
  assign fits       = AM_EXT_W'(cur) >= amt_ext;
  assign first_kind = (fit_mode_q == fpfa_pkg::FIT_FIRST) ||
                      (fit_mode_q == fpfa_pkg::FIT_NEXT);
  assign better     = !found_q ||
                      (fit_mode_q == fpfa_pkg::FIT_BEST  && cur < selval_q) ||
                      (fit_mode_q == fpfa_pkg::FIT_WORST && cur > selval_q);
  assign last       = (k_q + CNT_W'(1)) == n_q;
  assign j_inc      = CNT_W'(j_q) + CNT_W'(1);
  assign sel_inc    = CNT_W'(sel_q) + CNT_W'(1);
  assign remain     = selval_q - SIZE_W'(amount_q);

  assign stat_o.direct    = (amount_q == '0) || (kind_q == fpfa_pkg::KIND_LOAD) ||
                            (n_q == '0);
  assign stat_o.scan_done = last || (fits && first_kind);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    status_d = fpfa_pkg::ST_ZERO;
    chosen_d = '0;
    left_d   = '0;
    if (amount_q == '0) begin
      status_d = fpfa_pkg::ST_ZERO;
    end else if (kind_q == fpfa_pkg::KIND_LOAD) begin
      status_d = fpfa_pkg::ST_LOADED;
      chosen_d = part_index_q;
      if (load_ok) begin
        left_d = fpfa_pkg::AMT_W'(sat_val);
      end
    end else if (found_q) begin
      status_d = fpfa_pkg::ST_ALLOC;
      chosen_d = fpfa_pkg::PIDX_W'(sel_q);
      left_d   = fpfa_pkg::AMT_W'(remain);
    end else begin
      status_d = fpfa_pkg::ST_NOFIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= fpfa_pkg::FIT_FIRST;
      block_count_q <= fpfa_pkg::BCNT_W'(16);
      rover_q       <= '0;
      for (int i = 0; i < fpfa_pkg::NUM_BLOCKS; i++) begin
        free_q[i] <= '0;
      end
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (fpfa_pkg::cfg_reg_e'(cfg_index_i))
          fpfa_pkg::REG_FIT_MODE: begin
            fit_mode_q <= fpfa_pkg::fit_mode_e'(cfg_data_i[fpfa_pkg::MODE_W-1:0]);
          end
          fpfa_pkg::REG_BLOCK_COUNT: begin
            block_count_q <= cfg_data_i[fpfa_pkg::BCNT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end else if (cmd_i.step && fits && better) begin
        found_q <= 1'b1;
      end

      if (cmd_i.commit && amount_q != '0) begin
        if (kind_q == fpfa_pkg::KIND_LOAD) begin
          if (load_ok) begin
            free_q[IDX_W'(part_index_q)] <= sat_val;
            rover_q                      <= '0;
          end
        end else if (found_q) begin
          free_q[sel_q] <= remain;
          if (fit_mode_q == fpfa_pkg::FIT_NEXT) begin
            rover_q <= (sel_inc >= n_q) ? '0 : IDX_W'(sel_inc);
          end
        end
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q       <= fpfa_pkg::kind_e'(kind_i);
      part_index_q <= part_index_i;
      amount_q     <= amount_i;
      n_q          <= n_new;
      k_q          <= '0;
      j_q          <= start_idx;
    end else if (cmd_i.step) begin
      k_q <= k_q + CNT_W'(1);
      j_q <= (j_inc == n_q) ? '0 : IDX_W'(j_inc);
      if (fits && better) begin
        sel_q    <= j_q;
        selval_q <= cur;
      end
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      chosen_q <= chosen_d;
      left_q   <= left_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign chosen_index_o = chosen_q;
  assign space_left_o   = left_q;

endmodule

FILE: hdl/fixed_partition_fit_allocator_unit.sv
// channel   signals                                         direction
// in        in_valid_i in_ready_o kind_i part_index_i amount_i   into block
// out       out_valid_o out_ready_i status_o chosen_index_o
//           space_left_o                                   out of block
// cfg       cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  into block
//
// one word at a time: accept, then a scan over up to n entries of the
// partition table (n = effective block count), then commit. load and
// zero-size words skip the scan, as do allocations when n is zero.
// the scan reads one table entry a cycle, which sets the rate.
// reset clears the table and next-fit pointer, sets first fit and count 16.
// a result held on out stalls the commit, not the scan.
module fixed_partition_fit_allocator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fpfa_pkg::KIND_W-1:0]       kind_i,
  input  logic [fpfa_pkg::PIDX_W-1:0]       part_index_i,
  input  logic [fpfa_pkg::AMT_W-1:0]        amount_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpfa_pkg::STAT_W-1:0]       status_o,
  output logic [fpfa_pkg::PIDX_W-1:0]       chosen_index_o,
  output logic [fpfa_pkg::AMT_W-1:0]        space_left_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fpfa_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  fpfa_pkg::ctrl_cmd_t cmd;
  fpfa_pkg::dp_stat_t  stat;

  fpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpfa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .part_index_i   (part_index_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .chosen_index_o (chosen_index_o),
    .space_left_o   (space_left_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

endmodule

FILE: sim/fixed_partition_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_unit_tb;

  localparam int NUM_BLOCKS = fpfa_pkg::NUM_BLOCKS;
  localparam int SIZE_BITS  = fpfa_pkg::SIZE_BITS;
  localparam int KIND_W     = fpfa_pkg::KIND_W;
  localparam int PIDX_W     = fpfa_pkg::PIDX_W;
  localparam int AMT_W      = fpfa_pkg::AMT_W;
  localparam int STAT_W     = fpfa_pkg::STAT_W;
  localparam int MODE_W     = fpfa_pkg::MODE_W;
  localparam int BCNT_W     = fpfa_pkg::BCNT_W;
  localparam int CFG_IDX_W  = fpfa_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W  = fpfa_pkg::CFG_DAT_W;

  localparam int RANDOM_WORDS = 1625;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    fpfa_pkg::status_e   status;
    logic [PIDX_W-1:0]   idx;
    logic [AMT_W-1:0]    left;
  } outcome_t;

  typedef struct {
    bit                   is_cfg;
    fpfa_pkg::cfg_reg_e   reg_sel;
    logic [CFG_DAT_W-1:0] data;
    fpfa_pkg::kind_e      kind;
    logic [PIDX_W-1:0]    pidx;
    logic [AMT_W-1:0]     amt;
    bit                   typed;
    outcome_t             typed_out;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [PIDX_W-1:0]    part_index_i = '0;
  logic [AMT_W-1:0]     amount_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic [PIDX_W-1:0]    chosen_index_o;
  logic [AMT_W-1:0]     space_left_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  fixed_partition_fit_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .part_index_i  (part_index_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .chosen_index_o(chosen_index_o),
    .space_left_o  (space_left_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the partition table and registers
  logic [SIZE_BITS-1:0]  part_free [NUM_BLOCKS];
  int                    rover;
  fpfa_pkg::fit_mode_e   mode_reg;
  logic [BCNT_W-1:0]     count_reg;

  outcome_t  pending_outcomes [$];
  plan_row_t plan [$];
  outcome_t  want;

  int  errors = 0;
  int  words_in = 0;
  int  settings = 0;
  int  n_alloc = 0, n_nofit = 0, n_zero = 0, n_load = 0;
  int  hold_cycles = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int used_parts();
    return (count_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(count_reg);
  endfunction

  // applies one word to the shadow table and returns its result
  function automatic outcome_t compute_outcome(fpfa_pkg::kind_e k,
                                               logic [PIDX_W-1:0] pi,
                                               logic [AMT_W-1:0] amt);
    outcome_t o;
    int n, sel, j, start;
    o.status = fpfa_pkg::ST_ZERO;
    o.idx    = '0;
    o.left   = '0;
    if (amt == 0) return o;
    if (k == fpfa_pkg::KIND_LOAD) begin
      part_free[pi] = amt;
      rover         = 0;
      o.status      = fpfa_pkg::ST_LOADED;
      o.idx         = pi;
      o.left        = amt;
      return o;
    end
    n   = used_parts();
    sel = -1;
    if (mode_reg == fpfa_pkg::FIT_NEXT) begin
      start = (rover < n) ? rover : 0;
      for (int s = 0; s < n; s++) begin
        j = (start + s) % n;
        if (part_free[j] >= amt) begin
          sel = j;
          break;
        end
      end
    end else begin
      for (j = 0; j < n; j++) begin
        if (part_free[j] >= amt) begin
          if (sel < 0 ||
              (mode_reg == fpfa_pkg::FIT_BEST && part_free[j] < part_free[sel]) ||
              (mode_reg == fpfa_pkg::FIT_WORST && part_free[j] > part_free[sel]))
            sel = j;
          if (mode_reg == fpfa_pkg::FIT_FIRST) break;
        end
      end
    end
    if (sel < 0) begin
      o.status = fpfa_pkg::ST_NOFIT;
      return o;
    end
    part_free[sel] = part_free[sel] - amt;
    if (mode_reg == fpfa_pkg::FIT_NEXT) rover = (sel + 1 >= n) ? 0 : sel + 1;
    o.status = fpfa_pkg::ST_ALLOC;
    o.idx    = sel[PIDX_W-1:0];
    o.left   = part_free[sel];
    return o;
  endfunction

  function automatic void compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  task automatic put_word(fpfa_pkg::kind_e k, logic [PIDX_W-1:0] pi,
                          logic [AMT_W-1:0] amt, bit typed, outcome_t typed_out);
    int gap;
    outcome_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    part_index_i <= pi;
    amount_i     <= amt;
    do @(posedge clk_i); while (!in_ready_o);
    got = compute_outcome(k, pi, amt);
    pending_outcomes.push_back(typed ? typed_out : got);
    words_in++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // keep leaves valid up for a write that follows right away
  task automatic write_reg(fpfa_pkg::cfg_reg_e r, logic [CFG_DAT_W-1:0] d, bit keep);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (r == fpfa_pkg::REG_FIT_MODE) mode_reg = fpfa_pkg::fit_mode_e'(d[MODE_W-1:0]);
    else count_reg = d;
    settings++;
    if (!keep) cfg_valid_i <= 1'b0;
  endtask

  function automatic plan_row_t word_row(fpfa_pkg::kind_e k, logic [PIDX_W-1:0] pi,
                                         logic [AMT_W-1:0] amt);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_sel = fpfa_pkg::REG_FIT_MODE;
    row.data = '0;
    row.kind = k;
    row.pidx = pi;
    row.amt = amt;
    row.typed = 1'b0;
    row.typed_out.status = fpfa_pkg::ST_ZERO;
    row.typed_out.idx = '0;
    row.typed_out.left = '0;
    return row;
  endfunction

  task automatic add_word(fpfa_pkg::kind_e k, logic [PIDX_W-1:0] pi,
                          logic [AMT_W-1:0] amt);
    plan.push_back(word_row(k, pi, amt));
  endtask

  task automatic add_typed(fpfa_pkg::kind_e k, logic [PIDX_W-1:0] pi,
                           logic [AMT_W-1:0] amt, fpfa_pkg::status_e st,
                           logic [PIDX_W-1:0] ei, logic [AMT_W-1:0] el);
    plan_row_t row;
    row = word_row(k, pi, amt);
    row.typed = 1'b1;
    row.typed_out.status = st;
    row.typed_out.idx = ei;
    row.typed_out.left = el;
    plan.push_back(row);
  endtask

  task automatic add_reg(fpfa_pkg::cfg_reg_e r, logic [CFG_DAT_W-1:0] d);
    plan_row_t row;
    row = word_row(fpfa_pkg::KIND_LOAD, '0, '0);
    row.is_cfg = 1'b1;
    row.reg_sel = r;
    row.data = d;
    plan.push_back(row);
  endtask

  // result side: random stalls on the ready
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      hold_cycles <= pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result: status %0d index %0d space %0d", $time,
                 status_o, chosen_index_o, space_left_o);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("status", want.status, status_o);
        compare_field("chosen_index", want.idx, chosen_index_o);
        compare_field("space_left", want.left, space_left_o);
      end
      case (status_o)
        fpfa_pkg::ST_ALLOC: n_alloc++;
        fpfa_pkg::ST_NOFIT: n_nofit++;
        fpfa_pkg::ST_ZERO:  n_zero++;
        default:            n_load++;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t no handshake for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, pending_outcomes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int rand_sent, phase_len, r, eff, mode_v, cnt_v;
    fpfa_pkg::kind_e k;
    logic [PIDX_W-1:0] pi;
    logic [AMT_W-1:0] amt;

    for (int i = 0; i < NUM_BLOCKS; i++) part_free[i] = '0;
    rover     = 0;
    mode_reg  = fpfa_pkg::FIT_FIRST;
    count_reg = 5'd16;

    // after reset: empty table, first fit over all partitions
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd7, 16'd1, fpfa_pkg::ST_NOFIT, 4'd0, 16'd0);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd3, 16'd0, fpfa_pkg::ST_ZERO, 4'd0, 16'd0);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd15, 16'd0, fpfa_pkg::ST_ZERO, 4'd0, 16'd0);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd15, 16'hffff, fpfa_pkg::ST_LOADED, 4'd15,
              16'hffff);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd0, 16'd1, fpfa_pkg::ST_LOADED, 4'd0, 16'd1);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd0, 16'hffff, fpfa_pkg::ST_ALLOC, 4'd15, 16'd0);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd1, fpfa_pkg::ST_ALLOC, 4'd0, 16'd0);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd1, fpfa_pkg::ST_NOFIT, 4'd0, 16'd0);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd1, 16'd100, fpfa_pkg::ST_LOADED, 4'd1, 16'd100);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd2, 16'd40, fpfa_pkg::ST_LOADED, 4'd2, 16'd40);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd3, 16'd70, fpfa_pkg::ST_LOADED, 4'd3, 16'd70);
    // upper data bits of the mode write are don't-care
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b111, fpfa_pkg::FIT_BEST});
    add_word(fpfa_pkg::KIND_ALLOC, 4'd9, 16'd30);
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::FIT_WORST});
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd20);
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd80);
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b101, fpfa_pkg::FIT_NEXT});
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd5);
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd5);
    // pointer survives a mode change
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b010, fpfa_pkg::FIT_FIRST});
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd5);
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::FIT_NEXT});
    // pointer now past the count, scan restarts at zero
    add_reg(fpfa_pkg::REG_BLOCK_COUNT, 5'd4);
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd1);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd10, 16'd500, fpfa_pkg::ST_LOADED, 4'd10,
              16'd500);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd100, fpfa_pkg::ST_NOFIT, 4'd0, 16'd0);
    add_reg(fpfa_pkg::REG_BLOCK_COUNT, 5'd0);
    add_typed(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd1, fpfa_pkg::ST_NOFIT, 4'd0, 16'd0);
    add_reg(fpfa_pkg::REG_BLOCK_COUNT, 5'd31);
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd100);
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::FIT_BEST});
    add_reg(fpfa_pkg::REG_BLOCK_COUNT, 5'd16);
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd64);
    add_typed(fpfa_pkg::KIND_LOAD, 4'd5, 16'd400, fpfa_pkg::ST_LOADED, 4'd5, 16'd400);
    // equal space at 5 and 10, lower index wins
    add_reg(fpfa_pkg::REG_FIT_MODE, {3'b000, fpfa_pkg::FIT_WORST});
    add_word(fpfa_pkg::KIND_ALLOC, 4'd0, 16'd10);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].data,
                  (i + 1 < plan.size()) && plan[i + 1].is_cfg);
      end else begin
        put_word(plan[i].kind, plan[i].pidx, plan[i].amt, plan[i].typed,
                 plan[i].typed_out);
      end
    end

    rand_sent = 0;
    while (rand_sent < RANDOM_WORDS) begin
      drain();
      calm   = ($urandom_range(0, 4) == 0);
      mode_v = $urandom_range(0, 3);
      r      = $urandom_range(0, 99);
      if (r < 5) cnt_v = 0;
      else if (r < 15) cnt_v = $urandom_range(17, 31);
      else if (r < 25) cnt_v = 1;
      else if (r < 35) cnt_v = 16;
      else cnt_v = $urandom_range(2, 16);
      write_reg(fpfa_pkg::REG_FIT_MODE, {3'($urandom_range(0, 7)), 2'(mode_v)}, 1'b1);
      write_reg(fpfa_pkg::REG_BLOCK_COUNT, 5'(cnt_v), 1'b0);
      eff = used_parts();
      phase_len = $urandom_range(60, 140);
      for (int w = 0; w < phase_len; w++) begin
        r = $urandom_range(0, 99);
        // a phase opens by filling a few partitions
        if (w < 4 || r < 25) k = fpfa_pkg::KIND_LOAD;
        else k = fpfa_pkg::KIND_ALLOC;
        if (eff > 0 && $urandom_range(0, 9) < 7) pi = 4'($urandom_range(0, eff - 1));
        else pi = 4'($urandom_range(0, NUM_BLOCKS - 1));
        r = $urandom_range(0, 99);
        if (k == fpfa_pkg::KIND_LOAD)
          amt = (r < 80) ? 16'($urandom_range(1, 3000)) : 16'($urandom_range(1, 65535));
        else if (r < 85)
          amt = 16'($urandom_range(1, 800));
        else if (r < 95)
          amt = 16'($urandom_range(1, 65535));
        else
          amt = 16'($urandom_range(1, 4));
        if ($urandom_range(0, 99) < 3) amt = '0;
        put_word(k, pi, amt, 1'b0, want);
        rand_sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d words over %0d register writes: %0d allocated, %0d no fit,", words_in,
             settings, n_alloc, n_nofit);
    $display("%0d zero size, %0d loads; %0d mismatches", n_zero, n_load, errors);
    if (errors == 0 && pending_outcomes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/fpfa_pkg.sv
hdl/fpfa_ctrl.sv
hdl/fpfa_dp.sv
hdl/fixed_partition_fit_allocator_unit.sv
sim/fixed_partition_fit_allocator_unit_tb.sv
